// File: sv/gf32h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf32h_pkg
// shared types and constants for the gf(2^32) sequence hash
// ----------------------------------------------------------------------------
package gf32h_pkg;

  localparam int unsigned GfW          = 32;
  localparam logic [31:0] GfReducer    = 32'd141;
  localparam int unsigned LanesDef     = 2;
  localparam int unsigned LenBitsDef   = 20;
  localparam int unsigned OpW          = 3;
  localparam int unsigned CountW       = 16;
  localparam int unsigned OlenW        = 20;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_CONCAT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_MERGE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [0:0] {
    CFG_BASE0 = 1'b0,
    CFG_BASE1 = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_APP_MUL,
    ST_FIN_MUL,
    ST_COMMIT,
    ST_OUT
  } state_e;

endpackage

// File: sv/gf32_polynomial_sequence_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf32_polynomial_sequence_hash
// two-lane gf(2^32) rolling hash with append, concatenate, remove, merge, clear
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   op, word, count, other_length, other_hash_lane*
// out      output     out_valid/out_stall hash_lane0/1, seq_length, error
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data (base per lane)
//
// one item at a time through one shared bit-serial multiplier. append: count*LANES
// multiplies. concatenate / remove: per lane LENGTH_BITS-1 squarings, one multiply per set
// exponent bit and a final one. merge, clear, errors: no multiply; the item passes
// ST_CHECK and ST_COMMIT before the result is shown in ST_OUT.
// reset clears hashes and length and loads the bases 2, 3, ...
// a stalled result holds; the next item is taken once the result has gone.
// ----------------------------------------------------------------------------
module gf32_polynomial_sequence_hash
  import gf32h_pkg::*;
#(
  parameter int unsigned LANES       = LanesDef,
  parameter int unsigned LENGTH_BITS = LenBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OpW-1:0]    op_i,
  input  logic [GfW-1:0]    word_i,
  input  logic [CountW-1:0] count_i,
  input  logic [OlenW-1:0]  other_length_i,
  input  logic [GfW-1:0]    other_hash_lane0_i,
  input  logic [GfW-1:0]    other_hash_lane1_i,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [GfW-1:0]    hash_lane0_o,
  output logic [GfW-1:0]    hash_lane1_o,
  output logic [OlenW-1:0]  seq_length_o,
  output logic              error_o,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [GfW-1:0]    cfg_data
);

  localparam int unsigned LaneW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned EBitW = $clog2(LENGTH_BITS + 1);
  localparam int unsigned SumW  = ((LENGTH_BITS > OlenW) ? LENGTH_BITS : OlenW) + 1;

  state_e state_q, state_d;

  logic [GfW-1:0]         base_q [LANES];
  logic [GfW-1:0]         hash_q [LANES];
  logic [GfW-1:0]         other_q [LANES];
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [OpW-1:0]         op_q;
  logic [GfW-1:0]         word_q;
  logic [CountW-1:0]      cnt_q, cnt_d;
  logic [OlenW-1:0]       olen_q;
  logic [LENGTH_BITS-1:0] exp_q, exp_d;
  logic [EBitW-1:0]       ebit_q, ebit_d;
  logic [LaneW-1:0]       lane_q, lane_d;
  logic [GfW-1:0]         pw_q, pw_d, sq_q, sq_d;
  logic                   err_q, err_d;
  logic                   mul_start, mul_done;
  logic [GfW-1:0]         mul_a, mul_b, mul_p;
  logic                   wait_q, wait_d;
  logic [SumW-1:0]        sum_cnt, sum_olen;
  logic                   accept, last_lane;

  gf32h_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_q != ST_IDLE);
  assign cfg_ready = (state_q == ST_IDLE);
  assign out_valid = (state_q == ST_OUT);
  assign last_lane = (lane_q == LaneW'(LANES - 1));
  assign sum_cnt   = SumW'(len_q) + SumW'(cnt_q);
  assign sum_olen  = SumW'(len_q) + SumW'(olen_q);

  // next state and counters
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    exp_d     = exp_q;
    ebit_d    = ebit_q;
    lane_d    = lane_q;
    pw_d      = pw_q;
    sq_d      = sq_q;
    err_d     = err_q;
    wait_d    = wait_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CHECK;
          cnt_d   = count_i;
          lane_d  = '0;
          err_d   = 1'b0;
          wait_d  = 1'b0;
        end
      end
      ST_CHECK: begin
        state_d = ST_COMMIT;
        case (op_e'(op_q))
          OP_APPEND: begin
            if ((sum_cnt >> LENGTH_BITS) != '0) err_d = 1'b1;
            else if (cnt_q != '0) state_d = ST_APP_MUL;
          end
          OP_CONCAT: begin
            if ((sum_olen >> LENGTH_BITS) != '0) err_d = 1'b1;
            else begin
              exp_d   = LENGTH_BITS'(olen_q);
              state_d = ST_POW_MUL;
            end
          end
          OP_REMOVE: begin
            if (SumW'(olen_q) > SumW'(len_q)) err_d = 1'b1;
            else begin
              len_d   = LENGTH_BITS'(SumW'(len_q) - SumW'(olen_q));
              exp_d   = LENGTH_BITS'(SumW'(len_q) - SumW'(olen_q));
              state_d = ST_POW_MUL;
            end
          end
          OP_MERGE: begin
            if (SumW'(olen_q) != SumW'(len_q)) err_d = 1'b1;
          end
          OP_CLEAR: ;
          default: err_d = 1'b1;
        endcase
        pw_d   = 32'd1;
        sq_d   = base_q[0];
        ebit_d = '0;
      end
      ST_POW_MUL: begin
        // multiply result by square when the exponent bit is set
        if (!wait_q) begin
          if (exp_q[0]) wait_d = 1'b1;
          else state_d = ST_POW_SQR;
        end else if (mul_done) begin
          pw_d    = mul_p;
          wait_d  = 1'b0;
          state_d = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        if (ebit_q == EBitW'(LENGTH_BITS - 1)) state_d = ST_FIN_MUL;
        else if (!wait_q) begin
          wait_d    = 1'b1;
        end else if (mul_done) begin
          sq_d    = mul_p;
          wait_d  = 1'b0;
          exp_d   = exp_q >> 1;
          ebit_d  = ebit_q + 1'b1;
          state_d = ST_POW_MUL;
        end
      end
      ST_FIN_MUL: begin
        if (!wait_q) begin
          wait_d    = 1'b1;
        end else if (mul_done) begin
          wait_d = 1'b0;
          if (last_lane) state_d = ST_COMMIT;
          else begin
            lane_d  = lane_q + 1'b1;
            pw_d    = 32'd1;
            sq_d    = base_q[lane_q + 1'b1];
            ebit_d  = '0;
            exp_d   = (op_e'(op_q) == OP_CONCAT) ? LENGTH_BITS'(olen_q) : len_q;
            state_d = ST_POW_MUL;
          end
        end
      end
      ST_APP_MUL: begin
        if (!wait_q) begin
          wait_d    = 1'b1;
        end else if (mul_done) begin
          wait_d = 1'b0;
          if (last_lane) begin
            lane_d = '0;
            cnt_d  = cnt_q - 1'b1;
            len_d  = len_q + 1'b1;
            if (cnt_q == CountW'(1)) state_d = ST_COMMIT;
          end else lane_d = lane_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        if (!err_d && op_e'(op_q) == OP_CONCAT) len_d = LENGTH_BITS'(sum_olen);
        if (!err_d && op_e'(op_q) == OP_CLEAR) len_d = '0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // multiplier control
  always_comb begin
    mul_start = 1'b0;
    mul_a     = pw_q;
    mul_b     = sq_q;
    case (state_q)
      ST_POW_MUL: mul_start = !wait_q && exp_q[0];
      ST_POW_SQR: begin
        mul_a     = sq_q;
        mul_start = !wait_q && (ebit_q != EBitW'(LENGTH_BITS - 1));
      end
      ST_FIN_MUL: begin
        mul_a     = pw_q;
        mul_b     = (op_e'(op_q) == OP_CONCAT) ? hash_q[lane_q] : other_q[lane_q];
        mul_start = !wait_q;
      end
      ST_APP_MUL: begin
        mul_a     = hash_q[lane_q];
        mul_b     = base_q[lane_q];
        mul_start = !wait_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      err_q   <= 1'b0;
      wait_q  <= 1'b0;
      lane_q  <= '0;
      cnt_q   <= '0;
      ebit_q  <= '0;
      for (int l = 0; l < LANES; l++) begin
        base_q[l] <= GfW'(l + 2);
        hash_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      err_q   <= err_d;
      wait_q  <= wait_d;
      lane_q  <= lane_d;
      cnt_q   <= cnt_d;
      ebit_q  <= ebit_d;
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_e'(cfg_index) == CFG_BASE0) base_q[0] <= cfg_data;
        else if (LANES > 1) base_q[LANES > 1 ? 1 : 0] <= cfg_data;
      end
      // hash updates
      if (state_q == ST_APP_MUL && wait_q && mul_done)
        hash_q[lane_q] <= mul_p ^ word_q;
      if (state_q == ST_FIN_MUL && wait_q && mul_done) begin
        if (op_e'(op_q) == OP_CONCAT) hash_q[lane_q] <= mul_p ^ other_q[lane_q];
        else hash_q[lane_q] <= hash_q[lane_q] ^ mul_p;
      end
      if (state_q == ST_COMMIT && !err_q) begin
        for (int l = 0; l < LANES; l++) begin
          if (op_e'(op_q) == OP_MERGE) hash_q[l] <= hash_q[l] ^ other_q[l];
          if (op_e'(op_q) == OP_CLEAR) hash_q[l] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q  <= pw_d;
    sq_q  <= sq_d;
    exp_q <= exp_d;
    if (accept) begin
      op_q   <= op_i;
      word_q <= word_i;
      olen_q <= other_length_i;
      for (int l = 0; l < LANES; l++) begin
        other_q[l] <= (l == 0) ? other_hash_lane0_i :
                      (l == 1) ? other_hash_lane1_i : '0;
      end
    end
  end

  assign hash_lane0_o = hash_q[0];
  assign hash_lane1_o = (LANES > 1) ? hash_q[LANES > 1 ? 1 : 0] : '0;
  assign seq_length_o = OlenW'(len_q);
  assign error_o      = err_q;

endmodule

// File: sv/gf32h_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf32h_mul
// bit-serial carry-less multiplier reduced modulo x^32+x^7+x^3+x^2+1
// ----------------------------------------------------------------------------
module gf32h_mul
  import gf32h_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [GfW-1:0] a_i,
  input  logic [GfW-1:0] b_i,
  output logic           done_o,
  output logic [GfW-1:0] p_o
);

  localparam int unsigned CntW = $clog2(GfW);

  logic [GfW-1:0]  a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [GfW-1:0]  sh;

  // horner from the top bit of a: acc = acc*x ^ (a_bit ? b : 0)
  always_comb begin
    sh     = {acc_q[GfW-2:0], 1'b0} ^ (acc_q[GfW-1] ? GfReducer : '0);
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = sh ^ (a_q[GfW-1] ? b_q : '0);
      a_d   = {a_q[GfW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(GfW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// File: sv/gf32h_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf32h_checker
// port-level checks for the sequence hash
// ----------------------------------------------------------------------------
module gf32h_checker
  import gf32h_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cfg_ready,
  input logic error_o,
  input logic [OlenW-1:0] seq_length_o
);

  // no new item while a result is pending
  a_no_in_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("item taken while result pending");

  // config never ready while a result is shown
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready |-> !out_valid) else $error("cfg ready while busy");

  // a stalled result holds its valid, error and length
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(error_o) && $stable(seq_length_o))
    else $error("result changed under stall");

  // accepted item leads to busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> in_stall) else $error("not busy after item");

endmodule

bind gf32_polynomial_sequence_hash gf32h_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .cfg_ready   (cfg_ready),
  .error_o     (error_o),
  .seq_length_o(seq_length_o)
);
